>>> hw/rtl/spdc_pkg.sv
// ============================================================================
// spdc_pkg - shared types and constants for the sync packet deframer
// Parse phases, record layout passed from the parser to the output stage,
// and the fixed framing constants of the packet format.
// ============================================================================
package spdc_pkg;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HEADER = 3'd1,
        PH_BANDS  = 3'd2,
        PH_CKSUM  = 3'd3,
        PH_PAD    = 3'd4
    } phase_t;

    localparam logic        KIND_BAND = 1'b0;
    localparam logic        KIND_END  = 1'b1;

    localparam logic [31:0] SYNC_WORD = 32'hFF00FF00;
    localparam logic [15:0] SUM_SEED  = 16'd510;   // 0xff * 2
    localparam logic [15:0] LEN_BASE  = 16'd32;
    localparam logic [4:0]  HDR_LAST  = 5'd27;     // band count byte
    localparam logic [4:0]  BAND_LAST = 5'd7;      // eighth byte of a band

    // One queued result; checksum compare is left to the output stage.
    typedef struct packed {
        logic        kind;
        logic [7:0]  band_index;
        logic [15:0] c_reference;
        logic [15:0] a_reference;
        logic [15:0] c_signal;
        logic [15:0] a_signal;
        logic [23:0] serial;
        logic [31:0] timestamp_ms;
        logic [15:0] internal_temp;
        logic [7:0]  band_count;
        logic [15:0] rx_cksum;
        logic [15:0] calc_sum;
    } rec_t;

endpackage

>>> hw/rtl/spdc_front.sv
// ============================================================================
// spdc_front - sync hunt and packet parser
// Takes one byte per transfer, tracks the packet phase, captures header
// fields, accumulates the byte sum and pushes a record per band and per end.
// ============================================================================
module spdc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_byte_in,
    output logic                push_valid,
    input  logic                push_ready,
    output spdc_pkg::rec_t      push_rec
);
    import spdc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] window_reg, window_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  band_cnt_reg, band_cnt_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  bands_reg, bands_next;
    logic [63:0] asm_reg, asm_next;
    logic [63:0] dark_reg, dark_next;
    logic [23:0] serial_reg, serial_next;
    logic [31:0] time_reg, time_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] rx_reg, rx_next;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  band_inc;
    logic [15:0] expect_len;

    // Conservative: stall whenever the queue is full.
    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign b          = s_byte_in;
    assign band_inc   = band_cnt_reg + 8'd1;
    assign expect_len = LEN_BASE + {5'd0, b, 3'd0};

    always_comb begin
        phase_next    = phase_reg;
        window_next   = window_reg;
        pos_next      = pos_reg;
        band_cnt_next = band_cnt_reg;
        sum_next      = sum_reg;
        length_next   = length_reg;
        bands_next    = bands_reg;
        asm_next      = asm_reg;
        dark_next     = dark_reg;
        serial_next   = serial_reg;
        time_next     = time_reg;
        temp_next     = temp_reg;
        rx_next       = rx_reg;
        push_valid    = 1'b0;

        push_rec               = '0;
        push_rec.serial        = serial_reg;
        push_rec.timestamp_ms  = time_reg;
        push_rec.internal_temp = temp_reg;
        push_rec.band_count    = bands_reg;
        push_rec.rx_cksum      = rx_reg;
        push_rec.calc_sum      = sum_reg;

        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    sum_next = sum_reg + {8'd0, b};
                    // header byte offsets, big-endian fields
                    unique case (pos_reg) inside
                        [5'd0:5'd1]:   length_next = {length_reg[7:0], b};
                        [5'd5:5'd7]:   serial_next = {serial_reg[15:0], b};
                        [5'd8:5'd9]:   dark_next[47:32] = {dark_reg[39:32], b};
                        [5'd12:5'd13]: dark_next[15:0]  = {dark_reg[7:0], b};
                        [5'd16:5'd17]: temp_next = {temp_reg[7:0], b};
                        [5'd18:5'd19]: dark_next[63:48] = {dark_reg[55:48], b};
                        [5'd20:5'd21]: dark_next[31:16] = {dark_reg[23:16], b};
                        [5'd22:5'd25]: time_next = {time_reg[23:0], b};
                        default: ;
                    endcase
                    if (pos_reg == HDR_LAST) begin
                        bands_next = b;
                        pos_next   = '0;
                        if (length_reg != expect_len) begin
                            // drop, and resume hunting from this byte
                            phase_next  = PH_HUNT;
                            window_next = {24'd0, b};
                        end else begin
                            band_cnt_next = '0;
                            phase_next    = (b == 8'd0) ? PH_CKSUM : PH_BANDS;
                        end
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                PH_BANDS: begin
                    sum_next = sum_reg + {8'd0, b};
                    asm_next = {asm_reg[55:0], b};
                    if (pos_reg == BAND_LAST) begin
                        push_valid           = 1'b1;
                        push_rec.kind        = KIND_BAND;
                        push_rec.band_index  = band_cnt_reg;
                        push_rec.c_reference = asm_reg[55:40];
                        push_rec.a_reference = asm_reg[39:24];
                        push_rec.c_signal    = asm_reg[23:8];
                        push_rec.a_signal    = {asm_reg[7:0], b};
                        band_cnt_next        = band_inc;
                        pos_next             = '0;
                        if (band_inc == bands_reg) begin
                            phase_next = PH_CKSUM;
                        end
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                PH_CKSUM: begin
                    rx_next = {rx_reg[7:0], b};
                    if (pos_reg != 5'd0) begin
                        pos_next   = '0;
                        phase_next = PH_PAD;
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                PH_PAD: begin
                    push_valid           = 1'b1;
                    push_rec.kind        = KIND_END;
                    push_rec.band_index  = '0;
                    push_rec.c_reference = dark_reg[63:48];
                    push_rec.a_reference = dark_reg[47:32];
                    push_rec.c_signal    = dark_reg[31:16];
                    push_rec.a_signal    = dark_reg[15:0];
                    phase_next           = PH_HUNT;
                    window_next          = '0;
                    pos_next             = '0;
                end
                default: begin
                    window_next = {window_reg[23:0], b};
                    if ({window_reg[23:0], b} == SYNC_WORD) begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                        sum_next   = SUM_SEED;
                        rx_next    = '0;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            window_reg   <= '0;
            pos_reg      <= '0;
            band_cnt_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            window_reg   <= window_next;
            pos_reg      <= pos_next;
            band_cnt_reg <= band_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        length_reg <= length_next;
        bands_reg  <= bands_next;
        asm_reg    <= asm_next;
        dark_reg   <= dark_next;
        serial_reg <= serial_next;
        time_reg   <= time_next;
        temp_reg   <= temp_next;
        rx_reg     <= rx_next;
    end

endmodule

>>> hw/rtl/spdc_queue.sv
// ============================================================================
// spdc_queue - record queue between parser and output stage
// Small first-in first-out store of parsed records; each side stalls alone.
// ============================================================================
module spdc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  spdc_pkg::rec_t      push_rec,
    output logic                pop_valid,
    input  logic                pop_ready,
    output spdc_pkg::rec_t      pop_rec
);
    import spdc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

>>> hw/rtl/spdc_back.sv
// ============================================================================
// spdc_back - result formatter and output register
// Pops queued records, performs the checksum compare and holds the result
// until the downstream transfer completes.
// ============================================================================
module spdc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  spdc_pkg::rec_t      pop_rec,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic [7:0]          m_band_index,
    output logic [15:0]         m_c_reference,
    output logic [15:0]         m_a_reference,
    output logic [15:0]         m_c_signal,
    output logic [15:0]         m_a_signal,
    output logic [23:0]         m_serial,
    output logic [31:0]         m_timestamp_ms,
    output logic [15:0]         m_internal_temp_counts,
    output logic                m_checksum_ok,
    output logic [7:0]          m_band_count,
    output logic                m_last
);
    import spdc_pkg::*;

    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  index_reg;
    logic [15:0] cref_reg, aref_reg, csig_reg, asig_reg;
    logic [23:0] serial_reg;
    logic [31:0] time_reg;
    logic [15:0] temp_reg;
    logic        ok_reg;
    logic [7:0]  bands_reg;
    logic        is_end;
    logic        load;

    assign pop_ready = !valid_reg || m_ready;
    assign load      = pop_valid && pop_ready;
    assign is_end    = (pop_rec.kind == KIND_END);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop_ready) begin
            valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= pop_rec.kind;
            index_reg  <= pop_rec.band_index;
            cref_reg   <= pop_rec.c_reference;
            aref_reg   <= pop_rec.a_reference;
            csig_reg   <= pop_rec.c_signal;
            asig_reg   <= pop_rec.a_signal;
            serial_reg <= pop_rec.serial;
            time_reg   <= pop_rec.timestamp_ms;
            temp_reg   <= pop_rec.internal_temp;
            bands_reg  <= pop_rec.band_count;
            ok_reg     <= is_end && (pop_rec.rx_cksum == pop_rec.calc_sum);
        end
    end

    assign m_valid                = valid_reg;
    assign m_kind                 = kind_reg;
    assign m_band_index           = index_reg;
    assign m_c_reference          = cref_reg;
    assign m_a_reference          = aref_reg;
    assign m_c_signal             = csig_reg;
    assign m_a_signal             = asig_reg;
    assign m_serial               = serial_reg;
    assign m_timestamp_ms         = time_reg;
    assign m_internal_temp_counts = temp_reg;
    assign m_checksum_ok          = ok_reg;
    assign m_band_count           = bands_reg;
    assign m_last                 = kind_reg;

endmodule

>>> hw/rtl/sync_packet_deframer_checksum_top.sv
// ============================================================================
// sync_packet_deframer_checksum_top - sync word deframer with byte checksum
// Hunts for FF 00 FF 00, parses the packet header and bands, and emits one
// record per band plus an end record carrying the checksum status.
// ============================================================================
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   s_      | in        | s_valid / s_ready  | s_byte_in, one byte per transfer
//   m_      | out       | m_valid / m_ready  | band sample or end-of-packet record
//
// One byte is taken per cycle while s_ready is high; the parser updates position,
// fields and sum together. A record is written to the queue and then to the output
// register on m_; s_ready drops only when the queue (QUEUE_DEPTH entries) is full.
// aresetn (synchronous) returns the parser to sync hunting and empties the queue.
//
module sync_packet_deframer_checksum_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_band_index,
    output logic [15:0] m_c_reference,
    output logic [15:0] m_a_reference,
    output logic [15:0] m_c_signal,
    output logic [15:0] m_a_signal,
    output logic [23:0] m_serial,
    output logic [31:0] m_timestamp_ms,
    output logic [15:0] m_internal_temp_counts,
    output logic        m_checksum_ok,
    output logic [7:0]  m_band_count,
    output logic        m_last
);
    import spdc_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    rec_t push_rec, pop_rec;

    spdc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    spdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    spdc_back u_back (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .pop_valid              (pop_valid),
        .pop_ready              (pop_ready),
        .pop_rec                (pop_rec),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_kind                 (m_kind),
        .m_band_index           (m_band_index),
        .m_c_reference          (m_c_reference),
        .m_a_reference          (m_a_reference),
        .m_c_signal             (m_c_signal),
        .m_a_signal             (m_a_signal),
        .m_serial               (m_serial),
        .m_timestamp_ms         (m_timestamp_ms),
        .m_internal_temp_counts (m_internal_temp_counts),
        .m_checksum_ok          (m_checksum_ok),
        .m_band_count           (m_band_count),
        .m_last                 (m_last)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - sync packet deframer with additive checksum
// Feeds the byte stream from a short table of directed bytes and then from
// random packets, noise, length errors and cut-off packets. Each byte that is
// accepted goes through a bit-accurate parser kept here, and every record on
// m_ is compared field by field with the oldest record that it predicts.
// ============================================================================
module testbench;
    import spdc_pkg::*;

    localparam int RANDOM_ITEMS = 820;
    localparam int LONG_BANDS   = 32;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIRECTED_END_ROW = 34;

    typedef struct packed {
        logic        kind;
        logic [7:0]  band_index;
        logic [15:0] c_reference;
        logic [15:0] a_reference;
        logic [15:0] c_signal;
        logic [15:0] a_signal;
        logic [23:0] serial;
        logic [31:0] timestamp_ms;
        logic [15:0] internal_temp;
        logic        checksum_ok;
        logic [7:0]  band_count;
        logic        last;
    } record_t;

    // Zero-band packet, sync word hidden in the header, bad checksum.
    localparam logic [7:0] DIRECTED_BYTES [35] = '{
        8'hFF, 8'h00, 8'hFF, 8'h00,                 // sync
        8'h00, 8'h20,                               // length 32
        8'h00, 8'h00, 8'h00,                        // type, reserved, meter
        8'hFF, 8'hFF, 8'hFF,                        // serial
        8'h12, 8'h34,                               // a-ref dark
        8'hFF, 8'h00,                               // pressure
        8'hFF, 8'h00,                               // a-sig dark
        8'h00, 8'h00,                               // ext temp
        8'hFF, 8'hFF,                               // int temp
        8'h00, 8'h00,                               // c-ref dark
        8'h80, 8'h01,                               // c-sig dark
        8'hFF, 8'hFF, 8'hFF, 8'hFF,                 // msec
        8'h00, 8'h00,                               // reserved, band count
        8'h00, 8'h00,                               // checksum
        8'h00                                       // pad
    };

    localparam record_t DIRECTED_END_REC = '{
        kind: KIND_END, band_index: 8'd0,
        c_reference: 16'h0000, a_reference: 16'h1234,
        c_signal: 16'h8001, a_signal: 16'hFF00,
        serial: 24'hFFFFFF, timestamp_ms: 32'hFFFFFFFF,
        internal_temp: 16'hFFFF, checksum_ok: 1'b0,
        band_count: 8'd0, last: 1'b1
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [7:0]  m_band_index;
    logic [15:0] m_c_reference;
    logic [15:0] m_a_reference;
    logic [15:0] m_c_signal;
    logic [15:0] m_a_signal;
    logic [23:0] m_serial;
    logic [31:0] m_timestamp_ms;
    logic [15:0] m_internal_temp_counts;
    logic        m_checksum_ok;
    logic [7:0]  m_band_count;
    logic        m_last;

    sync_packet_deframer_checksum_top u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_byte_in             (s_byte_in),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_kind                (m_kind),
        .m_band_index          (m_band_index),
        .m_c_reference         (m_c_reference),
        .m_a_reference         (m_a_reference),
        .m_c_signal            (m_c_signal),
        .m_a_signal            (m_a_signal),
        .m_serial              (m_serial),
        .m_timestamp_ms        (m_timestamp_ms),
        .m_internal_temp_counts(m_internal_temp_counts),
        .m_checksum_ok         (m_checksum_ok),
        .m_band_count          (m_band_count),
        .m_last                (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t      parse_phase;
    logic [31:0] hunt_window;
    logic [15:0] field_pos;
    logic [15:0] byte_sum;
    logic [15:0] length_field;
    logic [7:0]  band_total;
    logic [7:0]  band_done;
    logic [63:0] band_bytes;
    logic [63:0] dark_counts;   // c-ref, a-ref, c-sig, a-sig from the top
    logic [23:0] serial_reg;
    logic [31:0] msec_reg;
    logic [15:0] temp_reg;
    logic [15:0] sum_field;

    record_t     pending_records [$];
    logic [7:0]  burst [$];
    record_t     head_rec;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    function automatic void clear_parser();
        parse_phase  = PH_HUNT;
        hunt_window  = '0;
        field_pos    = '0;
        byte_sum     = '0;
        length_field = '0;
        band_total   = '0;
        band_done    = '0;
        band_bytes   = '0;
        dark_counts  = '0;
        serial_reg   = '0;
        msec_reg     = '0;
        temp_reg     = '0;
        sum_field    = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, output bit emitted,
                                       output record_t rec);
        emitted = 1'b0;
        rec     = '0;
        case (parse_phase)
            PH_HEADER: begin
                byte_sum = byte_sum + {8'd0, b};
                if (field_pos <= 16'd1)
                    length_field = {length_field[7:0], b};
                else if (field_pos >= 16'd5 && field_pos <= 16'd7)
                    serial_reg = {serial_reg[15:0], b};
                else if (field_pos == 16'd8 || field_pos == 16'd9)
                    dark_counts[47:32] = {dark_counts[39:32], b};
                else if (field_pos == 16'd12 || field_pos == 16'd13)
                    dark_counts[15:0] = {dark_counts[7:0], b};
                else if (field_pos == 16'd16 || field_pos == 16'd17)
                    temp_reg = {temp_reg[7:0], b};
                else if (field_pos == 16'd18 || field_pos == 16'd19)
                    dark_counts[63:48] = {dark_counts[55:48], b};
                else if (field_pos == 16'd20 || field_pos == 16'd21)
                    dark_counts[31:16] = {dark_counts[23:16], b};
                else if (field_pos >= 16'd22 && field_pos <= 16'd25)
                    msec_reg = {msec_reg[23:0], b};
                if (field_pos == 16'(HDR_LAST)) begin
                    band_total = b;
                    if (length_field != LEN_BASE + {5'd0, b, 3'd0}) begin
                        // drop the packet; the count byte seeds the new hunt
                        parse_phase = PH_HUNT;
                        hunt_window = {24'd0, b};
                        field_pos   = '0;
                    end else begin
                        band_done   = '0;
                        field_pos   = '0;
                        parse_phase = (b == 8'd0) ? PH_CKSUM : PH_BANDS;
                    end
                end else begin
                    field_pos = field_pos + 16'd1;
                end
            end
            PH_BANDS: begin
                byte_sum   = byte_sum + {8'd0, b};
                band_bytes = {band_bytes[55:0], b};
                if (field_pos == 16'(BAND_LAST)) begin
                    emitted = 1'b1;
                    rec = '{kind: KIND_BAND, band_index: band_done,
                            c_reference: band_bytes[63:48], a_reference: band_bytes[47:32],
                            c_signal: band_bytes[31:16], a_signal: band_bytes[15:0],
                            serial: serial_reg, timestamp_ms: msec_reg,
                            internal_temp: temp_reg, checksum_ok: 1'b0,
                            band_count: band_total, last: 1'b0};
                    band_done = band_done + 8'd1;
                    field_pos = '0;
                    if (band_done == band_total)
                        parse_phase = PH_CKSUM;
                end else begin
                    field_pos = field_pos + 16'd1;
                end
            end
            PH_CKSUM: begin
                sum_field = {sum_field[7:0], b};
                if (field_pos >= 16'd1) begin
                    field_pos   = '0;
                    parse_phase = PH_PAD;
                end else begin
                    field_pos = field_pos + 16'd1;
                end
            end
            PH_PAD: begin
                emitted = 1'b1;
                rec = '{kind: KIND_END, band_index: 8'd0,
                        c_reference: dark_counts[63:48], a_reference: dark_counts[47:32],
                        c_signal: dark_counts[31:16], a_signal: dark_counts[15:0],
                        serial: serial_reg, timestamp_ms: msec_reg,
                        internal_temp: temp_reg, checksum_ok: (sum_field == byte_sum),
                        band_count: band_total, last: 1'b1};
                parse_phase = PH_HUNT;
                hunt_window = '0;
                field_pos   = '0;
            end
            default: begin
                hunt_window = {hunt_window[23:0], b};
                if (hunt_window == SYNC_WORD) begin
                    parse_phase = PH_HEADER;
                    field_pos   = '0;
                    byte_sum    = SUM_SEED;
                    sum_field   = '0;
                end else begin
                    parse_phase = PH_HUNT;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stream generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_byte(input int ext_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ext_pct / 2)
            return 8'h00;
        else if (r < ext_pct)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_bands();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(5, 12);
    endfunction

    // With a bad length only the sync and header are queued.
    task automatic add_packet(input int n_bands, input bit bad_len, input bit bad_sum);
        logic [15:0] len;
        logic [15:0] sum;
        logic [7:0]  b;
        begin
            burst.push_back(SYNC_WORD[31:24]);
            burst.push_back(SYNC_WORD[23:16]);
            burst.push_back(SYNC_WORD[15:8]);
            burst.push_back(SYNC_WORD[7:0]);
            len = LEN_BASE + 16'(n_bands) * 16'd8;
            if (bad_len) begin
                if ($urandom_range(0, 1) == 0)
                    len = len ^ (16'd1 << $urandom_range(0, 15));
                else
                    len = len ^ 16'($urandom_range(1, 65535));
            end
            sum = SUM_SEED;
            for (int k = 0; k <= int'(HDR_LAST); k++) begin
                if (k == 0)
                    b = len[15:8];
                else if (k == 1)
                    b = len[7:0];
                else if (k == int'(HDR_LAST))
                    b = 8'(n_bands);
                else
                    b = pick_byte(30);
                burst.push_back(b);
                sum = sum + {8'd0, b};
            end
            if (!bad_len) begin
                for (int k = 0; k < n_bands * 8; k++) begin
                    b = pick_byte(30);
                    burst.push_back(b);
                    sum = sum + {8'd0, b};
                end
                if (bad_sum)
                    sum = sum ^ 16'($urandom_range(1, 65535));
                burst.push_back(sum[15:8]);
                burst.push_back(sum[7:0]);
                burst.push_back(pick_byte(30));
            end
        end
    endtask

    task automatic build_burst();
        int r;
        int n;
        int mark;
        int cut;
        begin
            burst.delete();
            r = $urandom_range(0, 99);
            if (r < 65) begin
                add_packet(pick_bands(), 1'b0, $urandom_range(0, 3) == 0);
            end else if (r < 77) begin
                n = ($urandom_range(0, 2) == 0) ? 255 : pick_bands();
                add_packet(n, 1'b1, 1'b0);
                // count byte FF restarts the hunt with FF already in the window
                if (n == 255 && $urandom_range(0, 1) == 1) begin
                    mark = burst.size();
                    add_packet(pick_bands(), 1'b0, 1'b0);
                    burst.delete(mark);
                end
            end else if (r < 90) begin
                n = $urandom_range(1, 12);
                repeat (n) burst.push_back(pick_byte(80));
            end else begin
                mark = burst.size();
                add_packet(pick_bands(), 1'b0, 1'b0);
                cut = $urandom_range(mark + 1, burst.size() - 1);
                while (burst.size() > cut) void'(burst.pop_back());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] data, input bit typed,
                             input record_t typed_rec);
        bit      emitted;
        record_t rec;
        begin
            while ($urandom_range(0, 99) < src_idle_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid   <= 1'b1;
            s_byte_in <= data;
            do @(posedge aclk); while (s_ready !== 1'b1);
            parse_byte(data, emitted, rec);
            if (typed)
                pending_records.push_back(typed_rec);
            else if (emitted)
                pending_records.push_back(rec);
            @(negedge aclk);
        end
    endtask

    task automatic send_burst();
        foreach (burst[i]) send_byte(burst[i], 1'b0, '0);
    endtask

    // hold the input quiet until every predicted record has been taken
    task automatic wait_drained();
        begin
            s_valid <= 1'b0;
            do @(negedge aclk); while (pending_records.size() != 0);
        end
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_records.size() == 0) begin
                $error("record transfer with nothing pending (kind %0b band %0d)",
                       m_kind, m_band_index);
                error_count++;
            end else begin
                head_rec = pending_records.pop_front();
                check_field("kind", 32'(head_rec.kind), 32'(m_kind));
                check_field("band_index", 32'(head_rec.band_index), 32'(m_band_index));
                check_field("c_reference", 32'(head_rec.c_reference), 32'(m_c_reference));
                check_field("a_reference", 32'(head_rec.a_reference), 32'(m_a_reference));
                check_field("c_signal", 32'(head_rec.c_signal), 32'(m_c_signal));
                check_field("a_signal", 32'(head_rec.a_signal), 32'(m_a_signal));
                check_field("serial", 32'(head_rec.serial), 32'(m_serial));
                check_field("timestamp_ms", head_rec.timestamp_ms, m_timestamp_ms);
                check_field("internal_temp_counts", 32'(head_rec.internal_temp),
                            32'(m_internal_temp_counts));
                check_field("checksum_ok", 32'(head_rec.checksum_ok), 32'(m_checksum_ok));
                check_field("band_count", 32'(head_rec.band_count), 32'(m_band_count));
                check_field("last", 32'(head_rec.last), 32'(m_last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int sent;
        int target;
        clear_parser();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int row = 0; row < $size(DIRECTED_BYTES); row++)
            send_byte(DIRECTED_BYTES[row], row == DIRECTED_END_ROW, DIRECTED_END_REC);
        wait_drained();

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            if (ph == 0) begin
                // long packet, kept outside the random byte budget
                burst.delete();
                add_packet(LONG_BANDS, 1'b0, 1'b0);
                send_burst();
            end
            target = (ph + 1) * RANDOM_ITEMS / 4;
            while (sent < target) begin
                build_burst();
                sent += burst.size();
                send_burst();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
